// File: src/alag_pkg.sv
`default_nettype none
package alag_pkg;

    localparam int MAX_VECTORS  = 8;
    localparam int MAX_ELEMENTS = 256;
    localparam int MAX_ROWS     = 256;

    localparam logic [1:0] OP_LOAD_INPUT  = 2'd0;
    localparam logic [1:0] OP_LOAD_WEIGHT = 2'd1;
    localparam logic [1:0] OP_LOAD_BIAS   = 2'd2;
    localparam logic [1:0] OP_COMPUTE     = 2'd3;

    localparam logic [1:0] CFG_VECTOR_COUNT  = 2'd0;
    localparam logic [1:0] CFG_ELEMENT_COUNT = 2'd1;
    localparam logic [1:0] CFG_INPUT_IS_BYTE = 2'd2;
    localparam logic [1:0] CFG_BIAS_CODE     = 2'd3;

    localparam logic [1:0] BIAS_ONE_BYTE   = 2'd0;
    localparam logic [1:0] BIAS_TWO_BYTES  = 2'd1;
    localparam logic [1:0] BIAS_FOUR_BYTES = 2'd2;

    // weight token travelling down the cell chain
    typedef struct packed {
        logic        valid;
        logic [15:0] weight;
    } t_tok;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic        clr;
        logic        is_byte;
        logic [31:0] init;
    } t_ctl;

    function automatic logic [31:0] bias_ext(input logic [31:0] raw, input logic [1:0] code);
        logic [31:0] r;
        case (code)
            BIAS_ONE_BYTE:  r = {{24{raw[7]}}, raw[7:0]};
            BIAS_TWO_BYTES: r = {{16{raw[15]}}, raw[15:0]};
            default:        r = raw;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: src/alag_cell.sv
`default_nettype none
module alag_cell #(
    parameter int MAX_ELEMENTS = alag_pkg::MAX_ELEMENTS,
    localparam int EW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire alag_pkg::t_ctl  i_ctl,
    input  wire alag_pkg::t_tok  i_tok,
    input  wire logic [EW-1:0]   i_elem,
    output alag_pkg::t_tok       o_tok,
    output logic [EW-1:0]        o_elem,
    input  wire logic            i_wr_en,
    input  wire logic [EW-1:0]   i_wr_addr,
    input  wire logic [15:0]     i_wr_data,
    output logic [31:0]          o_acc
);

    logic [15:0]    r_xmem [MAX_ELEMENTS];
    alag_pkg::t_tok r_tok;
    logic [EW-1:0]  r_elem;
    logic [15:0]    r_x;
    logic           r_pvalid;
    logic [31:0]    r_prod;
    logic [31:0]    r_acc;
    logic [15:0]    w_x;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_xmem[i_wr_addr] <= i_wr_data;
        end
        r_x <= r_xmem[i_elem];
    end

    assign w_x = i_ctl.is_byte ? {{8{r_x[7]}}, r_x[7:0]} : r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_pvalid    <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
            r_pvalid    <= r_tok.valid;
        end
        r_tok.weight <= i_tok.weight;
        r_elem       <= i_elem;
        r_prod       <= 32'($signed(r_tok.weight)) * 32'($signed(w_x));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= i_ctl.init;
        end else if (r_pvalid) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_tok  = r_tok;
    assign o_elem = r_elem;
    assign o_acc  = r_acc;

endmodule
`default_nettype wire

// File: src/active_list_affine_gemv.sv
`default_nettype none
// Load transactions (input, weight, bias) are accepted while idle and keep busy
// low. A compute transaction keeps busy high through a bias read, one weight
// read per element of the clamped element count ne, streamed down a chain of
// MAX_VECTORS cells (one cell per input vector, each holding its vector and
// doing one multiply-accumulate per cycle), a drain of the chain, then one
// result per cycle for each of the nv vectors of the clamped vector count. With
// ne zero or a row beyond the store the stream is skipped. Results appear on
// o_strobe in the cycle after being selected and must be taken when shown: the
// receiver cannot stall.
module active_list_affine_gemv #(
    parameter int MAX_VECTORS  = alag_pkg::MAX_VECTORS,
    parameter int MAX_ELEMENTS = alag_pkg::MAX_ELEMENTS,
    parameter int MAX_ROWS     = alag_pkg::MAX_ROWS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [2:0]  i_vector_index,
    input  wire logic [7:0]  i_element_index,
    input  wire logic [7:0]  i_row_index,
    input  wire logic [7:0]  i_list_position,
    input  wire logic [15:0] i_data_value,
    input  wire logic [31:0] i_bias_value,
    input  wire logic        i_last_entry,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_wdata,
    output logic             o_strobe,
    output logic [31:0]      o_sum,
    output logic [7:0]       o_result_position,
    output logic [2:0]       o_result_vector,
    output logic             o_last_of_run,
    output logic             o_last_of_list
);

    localparam int EW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW  = $clog2(MAX_ELEMENTS + 1);
    localparam int VW  = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int NW  = $clog2(MAX_VECTORS + 1);
    localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int WD  = MAX_ROWS * MAX_ELEMENTS;
    localparam int WAW = (WD > 1) ? $clog2(WD) : 1;
    localparam int DW  = $clog2(MAX_VECTORS + 2);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BIAS   = 3'd1;
    localparam logic [2:0] S_STREAM = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    // configuration
    logic [3:0] r_vector_count;
    logic [8:0] r_element_count;
    logic       r_input_is_byte;
    logic [1:0] r_bias_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_count  <= 4'd1;
            r_element_count <= 9'd1;
            r_input_is_byte <= 1'b0;
            r_bias_code     <= alag_pkg::BIAS_FOUR_BYTES;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                alag_pkg::CFG_VECTOR_COUNT:  r_vector_count  <= i_cfg_wdata[3:0];
                alag_pkg::CFG_ELEMENT_COUNT: r_element_count <= i_cfg_wdata;
                alag_pkg::CFG_INPUT_IS_BYTE: r_input_is_byte <= i_cfg_wdata[0];
                alag_pkg::CFG_BIAS_CODE:     r_bias_code     <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    logic w_acc;
    logic w_elem_ok;
    logic w_row_ok;
    logic w_vec_ok;

    assign w_acc     = start && !busy;
    assign w_elem_ok = 32'(i_element_index) < MAX_ELEMENTS;
    assign w_row_ok  = 32'(i_row_index) < MAX_ROWS;
    assign w_vec_ok  = 32'(i_vector_index) < MAX_VECTORS;

    // weight and bias stores
    logic [15:0]    r_wmem [WD];
    logic [31:0]    r_bmem [MAX_ROWS];
    logic [15:0]    r_wdata;
    logic [31:0]    r_brd;
    logic           w_wt_we;
    logic           w_bias_we;
    logic [WAW-1:0] w_wt_waddr;
    logic [WAW-1:0] r_waddr;

    assign w_wt_we    = w_acc && i_op == alag_pkg::OP_LOAD_WEIGHT && w_row_ok && w_elem_ok;
    assign w_bias_we  = w_acc && i_op == alag_pkg::OP_LOAD_BIAS && w_row_ok;
    assign w_wt_waddr = WAW'(32'(i_row_index) * MAX_ELEMENTS + 32'(i_element_index));

    always_ff @(posedge i_clk) begin
        if (w_wt_we) begin
            r_wmem[w_wt_waddr] <= i_data_value;
        end
        r_wdata <= r_wmem[r_waddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_bias_we) begin
            r_bmem[RAW'(i_row_index)] <= i_bias_value;
        end
        r_brd <= r_bmem[RAW'(i_row_index)];
    end

    // sequencer
    logic [2:0]     r_state, n_state;
    logic [EW-1:0]  r_k, n_k;
    logic [WAW-1:0] n_waddr;
    logic [CW-1:0]  r_ne, n_ne;
    logic [NW-1:0]  r_nv, n_nv;
    logic [VW-1:0]  r_j, n_j;
    logic [DW-1:0]  r_dcnt, n_dcnt;
    logic           r_row_ok, n_row_ok;
    logic [7:0]     r_pos, n_pos;
    logic           r_last, n_last;
    logic           w_run_end;
    logic [31:0]    w_acc_sel;

    assign busy      = r_state != S_IDLE;
    assign w_run_end = NW'(r_j) == r_nv - NW'(1);

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_waddr  = r_waddr;
        n_ne     = r_ne;
        n_nv     = r_nv;
        n_j      = r_j;
        n_dcnt   = r_dcnt;
        n_row_ok = r_row_ok;
        n_pos    = r_pos;
        n_last   = r_last;
        case (r_state)
            S_IDLE: begin
                if (w_acc && i_op == alag_pkg::OP_COMPUTE) begin
                    n_state  = S_BIAS;
                    n_k      = '0;
                    n_waddr  = WAW'(32'(i_row_index) * MAX_ELEMENTS);
                    n_row_ok = w_row_ok;
                    n_pos    = i_list_position;
                    n_last   = i_last_entry;
                    if (r_vector_count == 4'd0) begin
                        n_nv = NW'(1);
                    end else if (32'(r_vector_count) > MAX_VECTORS) begin
                        n_nv = NW'(MAX_VECTORS);
                    end else begin
                        n_nv = NW'(r_vector_count);
                    end
                    if (32'(r_element_count) > MAX_ELEMENTS) begin
                        n_ne = CW'(MAX_ELEMENTS);
                    end else begin
                        n_ne = CW'(r_element_count);
                    end
                end
            end
            S_BIAS: begin
                if (r_row_ok && r_ne != '0) begin
                    n_state = S_STREAM;
                end else begin
                    n_state = S_DRAIN;
                    n_dcnt  = DW'(MAX_VECTORS + 1);
                end
            end
            S_STREAM: begin
                n_k     = r_k + EW'(1);
                n_waddr = r_waddr + WAW'(1);
                if (CW'(r_k) == r_ne - CW'(1)) begin
                    n_state = S_DRAIN;
                    n_dcnt  = DW'(MAX_VECTORS + 1);
                end
            end
            S_DRAIN: begin
                if (r_dcnt == '0) begin
                    n_state = S_EMIT;
                    n_j     = '0;
                end else begin
                    n_dcnt = r_dcnt - DW'(1);
                end
            end
            S_EMIT: begin
                n_j = r_j + VW'(1);
                if (w_run_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_k      <= n_k;
        r_waddr  <= n_waddr;
        r_ne     <= n_ne;
        r_nv     <= n_nv;
        r_j      <= n_j;
        r_dcnt   <= n_dcnt;
        r_row_ok <= n_row_ok;
        r_pos    <= n_pos;
        r_last   <= n_last;
    end

    // head of the chain: weight aligned with its element index
    logic          r_hvalid;
    logic [EW-1:0] r_helem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid <= 1'b0;
        end else begin
            r_hvalid <= r_state == S_STREAM;
        end
        r_helem <= r_k;
    end

    alag_pkg::t_ctl w_ctl;

    assign w_ctl.clr     = r_state == S_BIAS;
    assign w_ctl.is_byte = r_input_is_byte;
    assign w_ctl.init    = r_row_ok ? alag_pkg::bias_ext(r_brd, r_bias_code) : 32'd0;

    alag_pkg::t_tok w_tok  [MAX_VECTORS + 1];
    logic [EW-1:0]  w_elem [MAX_VECTORS + 1];
    logic [31:0]    w_accs [MAX_VECTORS];

    assign w_tok[0].valid  = r_hvalid;
    assign w_tok[0].weight = r_wdata;
    assign w_elem[0]       = r_helem;

    for (genvar g = 0; g < MAX_VECTORS; g++) begin : g_cell
        logic w_we;

        assign w_we = w_acc && i_op == alag_pkg::OP_LOAD_INPUT && w_vec_ok && w_elem_ok
                      && 32'(i_vector_index) == g;

        alag_cell #(
            .MAX_ELEMENTS(MAX_ELEMENTS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_tok     (w_tok[g]),
            .i_elem    (w_elem[g]),
            .o_tok     (w_tok[g + 1]),
            .o_elem    (w_elem[g + 1]),
            .i_wr_en   (w_we),
            .i_wr_addr (EW'(i_element_index)),
            .i_wr_data (i_data_value),
            .o_acc     (w_accs[g])
        );
    end

    assign w_acc_sel = w_accs[r_j];

    // result register
    logic        r_strobe;
    logic [31:0] r_sum;
    logic [7:0]  r_rpos;
    logic [2:0]  r_rvec;
    logic        r_lrun;
    logic        r_llist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_state == S_EMIT;
        end
        r_sum   <= w_acc_sel;
        r_rpos  <= r_pos;
        r_rvec  <= 3'(r_j);
        r_lrun  <= w_run_end;
        r_llist <= w_run_end && r_last;
    end

    assign o_strobe          = r_strobe;
    assign o_sum             = r_sum;
    assign o_result_position = r_rpos;
    assign o_result_vector   = r_rvec;
    assign o_last_of_run     = r_lrun;
    assign o_last_of_list    = r_llist;

endmodule
`default_nettype wire

// File: tb/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV_MAX = alag_pkg::MAX_VECTORS;
    localparam int NE_MAX = alag_pkg::MAX_ELEMENTS;
    localparam int NR_MAX = alag_pkg::MAX_ROWS;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 2 * NV_MAX + 16;
    localparam logic [1:0] BIAS_SPARE_CODE = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [2:0]  vec;
        logic [7:0]  elem;
        logic [7:0]  row;
        logic [7:0]  pos;
        logic [15:0] data;
        logic [31:0] bias;
        logic        last;
        bit          hold;
    } t_job;

    typedef struct {
        logic [31:0] sum;
        logic [7:0]  pos;
        logic [2:0]  vec;
        logic        run_end;
        logic        list_end;
    } t_row_sum;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_op = '0;
    logic [2:0]  i_vector_index = '0;
    logic [7:0]  i_element_index = '0;
    logic [7:0]  i_row_index = '0;
    logic [7:0]  i_list_position = '0;
    logic [15:0] i_data_value = '0;
    logic [31:0] i_bias_value = '0;
    logic        i_last_entry = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [8:0]  i_cfg_wdata = '0;
    logic        o_strobe;
    logic [31:0] o_sum;
    logic [7:0]  o_result_position;
    logic [2:0]  o_result_vector;
    logic        o_last_of_run;
    logic        o_last_of_list;

    active_list_affine_gemv dut (.*);

    always #10ns i_clk = ~i_clk;

    // pending transactions and expected row sums
    t_job     jobs [$];
    t_row_sum sums_due [$];

    // predictor state
    logic [15:0] in_mem [NV_MAX][NE_MAX];
    logic [15:0] wt_mem [NR_MAX][NE_MAX];
    logic [31:0] bias_mem [NR_MAX];
    logic [3:0]  cfg_vectors;
    logic [8:0]  cfg_elements;
    logic        cfg_byte;
    logic [1:0]  cfg_bias_code;

    // which store entries the stimulus has queued a write for so far
    bit in_set [NV_MAX][NE_MAX];
    bit wt_set [NR_MAX][NE_MAX];
    bit bias_set [NR_MAX];
    int gen_nv = 1;
    int gen_ne = 1;

    int          faults = 0;
    int unsigned cycles = 0;
    int          idle_left = 0;
    bit          burst = 1'b0;
    bit          took = 1'b0;

    function automatic void log_fault(input string msg);
        faults++;
        if (faults <= 10) $display("%s", msg);
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hff80;
            3: return 16'h007f;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_bias();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_ff80;
            default: return $urandom;
        endcase
    endfunction

    function automatic void put(input logic [1:0] op, input logic [2:0] vec,
                                input logic [7:0] elem, input logic [7:0] row,
                                input logic [7:0] pos, input logic [15:0] data,
                                input logic [31:0] bias, input logic last, input bit hold);
        t_job t;
        t.op = op;
        t.vec = vec;
        t.elem = elem;
        t.row = row;
        t.pos = pos;
        t.data = data;
        t.bias = bias;
        t.last = last;
        t.hold = hold;
        jobs.push_back(t);
        case (op)
            alag_pkg::OP_LOAD_INPUT:  in_set[vec][elem] = 1'b1;
            alag_pkg::OP_LOAD_WEIGHT: wt_set[row][elem] = 1'b1;
            alag_pkg::OP_LOAD_BIAS:   bias_set[row] = 1'b1;
            default: ;
        endcase
    endfunction

    // write everything a compute on this row reads under the current sizes
    function automatic void prepare_row(input logic [7:0] row);
        for (int k = 0; k < gen_ne; k++)
            if (!wt_set[row][k])
                put(alag_pkg::OP_LOAD_WEIGHT, 3'($urandom), 8'(k), row, 8'($urandom),
                    pick_word(), $urandom, 1'($urandom), 1'b0);
        for (int j = 0; j < gen_nv; j++)
            for (int k = 0; k < gen_ne; k++)
                if (!in_set[j][k])
                    put(alag_pkg::OP_LOAD_INPUT, 3'(j), 8'(k), 8'($urandom), 8'($urandom),
                        pick_word(), $urandom, 1'($urandom), 1'b0);
        if (!bias_set[row])
            put(alag_pkg::OP_LOAD_BIAS, 3'($urandom), 8'($urandom), row, 8'($urandom),
                16'($urandom), pick_bias(), 1'($urandom), 1'b0);
    endfunction

    function automatic void random_phase(input int count, input int pool_n,
                                         input logic [7:0] corner_row);
        logic [7:0] pool [8];
        logic [7:0] r;
        int         span;
        bit         hold;
        for (int i = 0; i < 8; i++) pool[i] = 8'($urandom);
        pool[0] = corner_row;
        span = (gen_ne > 0) ? gen_ne - 1 : 255;
        for (int i = 0; i < count; i++) begin
            r = pool[$urandom_range(0, pool_n - 1)];
            hold = ($urandom_range(0, 24) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    prepare_row(r);
                    put(alag_pkg::OP_COMPUTE, 3'($urandom), 8'($urandom), r, 8'($urandom),
                        16'($urandom), $urandom, 1'($urandom), hold);
                end
                4, 5: put(alag_pkg::OP_LOAD_INPUT, 3'($urandom_range(0, gen_nv - 1)),
                          8'($urandom_range(0, span)), 8'($urandom), 8'($urandom),
                          pick_word(), $urandom, 1'($urandom), hold);
                6, 7: put(alag_pkg::OP_LOAD_WEIGHT, 3'($urandom),
                          8'($urandom_range(0, span)), r, 8'($urandom), pick_word(),
                          $urandom, 1'($urandom), hold);
                8: put(alag_pkg::OP_LOAD_BIAS, 3'($urandom), 8'($urandom), r, 8'($urandom),
                       16'($urandom), pick_bias(), 1'($urandom), hold);
                default: put(2'($urandom_range(0, 2)), 3'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom), pick_word(), pick_bias(),
                             1'($urandom), hold);
            endcase
        end
    endfunction

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        logic [8:0] junk;
        case (idx)
            alag_pkg::CFG_VECTOR_COUNT:  junk = 9'h1f0;
            alag_pkg::CFG_ELEMENT_COUNT: junk = 9'h000;
            alag_pkg::CFG_INPUT_IS_BYTE: junk = 9'h1fe;
            default:                     junk = 9'h1fc;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= 9'(val) | (junk & 9'($urandom));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        do @(posedge i_clk);
        while (jobs.size() > 0 || start || busy || sums_due.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // driver
    always @(negedge i_clk) begin
        t_job nx;
        logic go;
        go = start;
        if (!i_rst_n) begin
            go = 1'b0;
        end else begin
            if (took) go = 1'b0;
            if (!go) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (jobs.size() > 0 && !(jobs[0].hold && sums_due.size() > 0)) begin
                    nx = jobs.pop_front();
                    i_op <= nx.op;
                    i_vector_index <= nx.vec;
                    i_element_index <= nx.elem;
                    i_row_index <= nx.row;
                    i_list_position <= nx.pos;
                    i_data_value <= nx.data;
                    i_bias_value <= nx.bias;
                    i_last_entry <= nx.last;
                    go = 1'b1;
                    if ($urandom_range(0, 15) == 0) burst = !burst;
                    idle_left = burst ? 0 : $urandom_range(0, 6);
                end
            end
        end
        start <= go;
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        t_row_sum           want;
        int                 nv;
        int                 ne;
        logic [31:0]        acc;
        logic [15:0]        x;
        logic signed [31:0] prod;
        if (!i_rst_n) begin
            cfg_vectors = 4'd1;
            cfg_elements = 9'd1;
            cfg_byte = 1'b0;
            cfg_bias_code = alag_pkg::BIAS_FOUR_BYTES;
            sums_due.delete();
            took <= 1'b0;
        end else begin
            if (o_strobe) begin
                if (sums_due.size() == 0) begin
                    log_fault($sformatf("unexpected result: sum %h pos %0d vec %0d",
                                        o_sum, o_result_position, o_result_vector));
                end else begin
                    want = sums_due.pop_front();
                    if (o_sum !== want.sum || o_result_position !== want.pos ||
                        o_result_vector !== want.vec || o_last_of_run !== want.run_end ||
                        o_last_of_list !== want.list_end)
                        log_fault($sformatf({"mismatch exp/act: sum %h/%h pos %0d/%0d ",
                                             "vec %0d/%0d run %b/%b list %b/%b"},
                                            want.sum, o_sum, want.pos, o_result_position,
                                            want.vec, o_result_vector, want.run_end,
                                            o_last_of_run, want.list_end, o_last_of_list));
                end
            end
            took <= start && !busy;
            if (start && !busy) begin
                case (i_op)
                    alag_pkg::OP_LOAD_INPUT:
                        if (int'(i_vector_index) < NV_MAX && int'(i_element_index) < NE_MAX)
                            in_mem[i_vector_index][i_element_index] = i_data_value;
                    alag_pkg::OP_LOAD_WEIGHT:
                        if (int'(i_row_index) < NR_MAX && int'(i_element_index) < NE_MAX)
                            wt_mem[i_row_index][i_element_index] = i_data_value;
                    alag_pkg::OP_LOAD_BIAS:
                        if (int'(i_row_index) < NR_MAX) bias_mem[i_row_index] = i_bias_value;
                    default: begin
                        nv = (cfg_vectors == 0) ? 1 :
                             (int'(cfg_vectors) > NV_MAX ? NV_MAX : int'(cfg_vectors));
                        ne = (int'(cfg_elements) > NE_MAX) ? NE_MAX : int'(cfg_elements);
                        for (int j = 0; j < nv; j++) begin
                            acc = 32'd0;
                            if (int'(i_row_index) < NR_MAX) begin
                                case (cfg_bias_code)
                                    alag_pkg::BIAS_ONE_BYTE:
                                        acc = {{24{bias_mem[i_row_index][7]}},
                                               bias_mem[i_row_index][7:0]};
                                    alag_pkg::BIAS_TWO_BYTES:
                                        acc = {{16{bias_mem[i_row_index][15]}},
                                               bias_mem[i_row_index][15:0]};
                                    default: acc = bias_mem[i_row_index];
                                endcase
                                for (int k = 0; k < ne; k++) begin
                                    x = cfg_byte ? {{8{in_mem[j][k][7]}}, in_mem[j][k][7:0]}
                                                 : in_mem[j][k];
                                    prod = 32'($signed(wt_mem[i_row_index][k]))
                                           * 32'($signed(x));
                                    acc = acc + prod;
                                end
                            end
                            want.sum = acc;
                            want.pos = i_list_position;
                            want.vec = 3'(j);
                            want.run_end = (j + 1 == nv);
                            want.list_end = (j + 1 == nv) && i_last_entry;
                            sums_due.push_back(want);
                        end
                    end
                endcase
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    alag_pkg::CFG_VECTOR_COUNT:  cfg_vectors = i_cfg_wdata[3:0];
                    alag_pkg::CFG_ELEMENT_COUNT: cfg_elements = i_cfg_wdata;
                    alag_pkg::CFG_INPUT_IS_BYTE: cfg_byte = i_cfg_wdata[0];
                    alag_pkg::CFG_BIAS_CODE:     cfg_bias_code = i_cfg_wdata[1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int vc;
        int ec;
        int ib;
        int cnt;
        int pool_n;
        logic [1:0] bc;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes: one vector, one element, word inputs, four-byte bias
        put(alag_pkg::OP_LOAD_INPUT, 3'd0, 8'd0, 8'd17, 8'd3, 16'h8000, 32'h0, 1'b0, 1'b0);
        put(alag_pkg::OP_LOAD_WEIGHT, 3'd7, 8'd0, 8'd0, 8'd255, 16'h8000, 32'hffff_ffff,
            1'b1, 1'b0);
        put(alag_pkg::OP_LOAD_BIAS, 3'd5, 8'd255, 8'd0, 8'd0, 16'h7fff, 32'h7fff_ffff,
            1'b0, 1'b0);
        put(alag_pkg::OP_COMPUTE, 3'd0, 8'd0, 8'd0, 8'd0, 16'h0, 32'h0, 1'b1, 1'b0);
        put(alag_pkg::OP_LOAD_INPUT, 3'd7, 8'd255, 8'd255, 8'd0, 16'h7fff, 32'h8000_0000,
            1'b1, 1'b0);
        put(alag_pkg::OP_LOAD_WEIGHT, 3'd0, 8'd255, 8'd255, 8'd128, 16'h7fff, 32'h0,
            1'b0, 1'b0);
        put(alag_pkg::OP_LOAD_WEIGHT, 3'd2, 8'd0, 8'd255, 8'd64, 16'h7fff, 32'h1234_5678,
            1'b0, 1'b0);
        put(alag_pkg::OP_LOAD_BIAS, 3'd0, 8'd0, 8'd255, 8'd1, 16'hffff, 32'h8000_0000,
            1'b1, 1'b0);
        put(alag_pkg::OP_LOAD_INPUT, 3'd0, 8'd0, 8'd0, 8'd2, 16'h7fff, 32'h0, 1'b0, 1'b0);
        put(alag_pkg::OP_COMPUTE, 3'd7, 8'd255, 8'd255, 8'd255, 16'hffff, 32'hffff_ffff,
            1'b0, 1'b0);
        put(alag_pkg::OP_LOAD_BIAS, 3'd1, 8'd1, 8'd0, 8'd4, 16'h0, 32'hffff_ffff, 1'b0, 1'b0);
        put(alag_pkg::OP_COMPUTE, 3'd3, 8'd3, 8'd0, 8'haa, 16'h5555, 32'haaaa_aaaa,
            1'b1, 1'b1);
        put(alag_pkg::OP_LOAD_WEIGHT, 3'd0, 8'd0, 8'd0, 8'd5, 16'h0001, 32'h0, 1'b0, 1'b0);
        put(alag_pkg::OP_LOAD_INPUT, 3'd0, 8'd0, 8'd0, 8'd6, 16'hffff, 32'h0, 1'b1, 1'b0);
        put(alag_pkg::OP_COMPUTE, 3'd0, 8'd0, 8'd0, 8'h55, 16'haaaa, 32'h5555_5555,
            1'b0, 1'b0);
        random_phase(16, 4, 8'd255);
        settle();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin vc = 0;  ec = 0; ib = 1; bc = alag_pkg::BIAS_ONE_BYTE;   cnt = 10; end
                1: begin vc = 8;  ec = 2; ib = 1; bc = alag_pkg::BIAS_TWO_BYTES;  cnt = 14; end
                2: begin vc = 15; ec = 3; ib = 0; bc = BIAS_SPARE_CODE;           cnt = 14; end
                3: begin vc = 3;  ec = 7; ib = 0; bc = alag_pkg::BIAS_FOUR_BYTES; cnt = 10; end
                default: begin
                    vc = 2; ec = 4; ib = 1; bc = alag_pkg::BIAS_TWO_BYTES; cnt = 14;
                end
            endcase
            pool_n = (ec > 4) ? 2 : 3;
            write_reg(alag_pkg::CFG_VECTOR_COUNT, vc);
            write_reg(alag_pkg::CFG_ELEMENT_COUNT, ec);
            write_reg(alag_pkg::CFG_INPUT_IS_BYTE, ib);
            write_reg(alag_pkg::CFG_BIAS_CODE, bc);
            gen_nv = (vc == 0) ? 1 : (vc > NV_MAX ? NV_MAX : vc);
            gen_ne = (ec > NE_MAX) ? NE_MAX : ec;
            random_phase(cnt, pool_n, (ph % 2) ? 8'd0 : 8'd255);
            settle();
        end

        if (faults == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
